// ----- rtl/core/sskf_pkg.sv -----
`timescale 1ns / 1ps

package sskf_pkg;

   // input command codes
   localparam logic [2:0] CMD_INIT = 3'd0;
   localparam logic [2:0] CMD_FINI = 3'd1;
   localparam logic [2:0] CMD_TICK = 3'd2;
   localparam logic [2:0] CMD_MSG  = 3'd3;
   localparam logic [2:0] CMD_ROLE = 3'd4;

   // received message classes
   localparam logic [3:0] CLS_FEAT_REQ  = 4'd0;
   localparam logic [3:0] CLS_ECHO_REQ  = 4'd1;
   localparam logic [3:0] CLS_ECHO_RES  = 4'd2;
   localparam logic [3:0] CLS_PKT_OUT   = 4'd6;
   localparam logic [3:0] CLS_FLOW_MOD  = 4'd7;
   localparam logic [3:0] CLS_GROUP_MOD = 4'd8;
   localparam logic [3:0] CLS_PORT_MOD  = 4'd9;
   localparam logic [3:0] CLS_TABLE_MOD = 4'd10;
   localparam logic [3:0] CLS_ROLE_REQ  = 4'd14;
   localparam logic [3:0] CLS_OTHER     = 4'd15;

   localparam logic [1:0] ROLE_SLAVE = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_FEATURE_WAIT  = 2'd0;
   localparam logic [1:0] CSR_ECHO_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_ECHO_WAIT     = 2'd2;

   localparam logic [31:0] FEATURE_WAIT_RESET  = 32'd5000;
   localparam logic [31:0] ECHO_INTERVAL_RESET = 32'd5000;
   localparam logic [31:0] ECHO_WAIT_RESET     = 32'd1000;

   typedef enum logic [3:0] {
      ACT_NONE       = 4'd0,
      ACT_FEAT_REPLY = 4'd1,
      ACT_ECHO_REQ   = 4'd2,
      ACT_ECHO_REPLY = 4'd3,
      ACT_SLAVE_ERR  = 4'd4,
      ACT_TO_AGENT   = 4'd5,
      ACT_FAILED     = 4'd6,
      ACT_AGENT_INIT = 4'd7,
      ACT_AGENT_FINI = 4'd8
   } action_type;

   typedef struct packed {
      logic [31:0] feature_wait_ticks;
      logic [31:0] echo_interval_ticks;
      logic [31:0] echo_wait_ticks;
   } cfg_type;

   typedef struct packed {
      action_type  action;
      logic [3:0]  agent_msg;
      logic        ok;
      logic [1:0]  conn_state;
      logic        last;
   } rsp_entry_type;

   // result pushes from the session core into the output queue
   typedef struct packed {
      logic          push0;
      logic          push1;
      rsp_entry_type res0;
      rsp_entry_type res1;
   } rsp_push_type;

endpackage

// ----- rtl/core/sskf_session.sv -----
`timescale 1ns / 1ps

module sskf_session #(
   parameter int TIME_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2:0]             in_cmd,
   input  logic [31:0]            in_now,
   input  logic [3:0]             in_msg_class,
   input  logic [1:0]             in_new_role,
   input  sskf_pkg::cfg_type      cfg,
   input  logic                   out_room,
   output sskf_pkg::rsp_push_type push
);

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_WAIT = 2'd1,
      S_ESTB = 2'd2,
      S_FAIL = 2'd3
   } state_type;

   typedef logic [TIME_BITS-1:0] time_type;

   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
   endfunction

   // input register
   logic       valid_ff;
   logic [2:0] cmd_ff;
   logic [31:0] now_ff;
   logic [3:0] cls_ff;
   logic [1:0] role_in_ff;

   // session state
   state_type  state_ff, state_in;
   logic [1:0] role_ff, role_in;
   time_type   fdl_ff, fdl_in;
   time_type   esd_ff, esd_in;
   logic       pend_ff, pend_in;
   time_type   rdl_ff, rdl_in;

   logic       fire;
   time_type   now_t;
   time_type   fdl_new, esd_new, rdl_new, rdl_eff;
   logic       send, pend_eff, echo_fail;
   logic       ok;
   logic       two;
   sskf_pkg::action_type act0, act1;
   logic [3:0] msg0;

   assign fire     = valid_ff && out_room;
   assign in_ready = !valid_ff || out_room;

   assign now_t   = TIME_BITS'(now_ff);
   assign fdl_new = sat_add(now_t, TIME_BITS'(cfg.feature_wait_ticks));
   assign esd_new = sat_add(now_t, TIME_BITS'(cfg.echo_interval_ticks));
   assign rdl_new = sat_add(now_t, TIME_BITS'(cfg.echo_wait_ticks));

   // keepalive check on a tick while established
   assign send      = now_t >= esd_ff;
   assign pend_eff  = pend_ff || send;
   assign rdl_eff   = (send && !pend_ff) ? rdl_new : rdl_ff;
   assign echo_fail = pend_eff && (now_t >= rdl_eff);

   // next state and results of the item in the input register
   always_comb begin
      state_in = state_ff;
      role_in  = role_ff;
      fdl_in   = fdl_ff;
      esd_in   = esd_ff;
      pend_in  = pend_ff;
      rdl_in   = rdl_ff;
      ok       = 1'b1;
      two      = 1'b0;
      act0     = sskf_pkg::ACT_NONE;
      act1     = sskf_pkg::ACT_NONE;
      msg0     = 4'd0;
      unique case (cmd_ff)
         sskf_pkg::CMD_INIT: begin
            if (state_ff == S_IDLE) begin
               state_in = S_WAIT;
               fdl_in   = fdl_new;
               act0     = sskf_pkg::ACT_AGENT_INIT;
            end else begin
               state_in = S_FAIL;
               pend_in  = 1'b0;
               act0     = sskf_pkg::ACT_FAILED;
               ok       = 1'b0;
            end
         end
         sskf_pkg::CMD_FINI: begin
            state_in = S_IDLE;
            pend_in  = 1'b0;
            act0     = sskf_pkg::ACT_AGENT_FINI;
            ok       = 1'b0;
         end
         sskf_pkg::CMD_TICK: begin
            if (state_ff == S_WAIT) begin
               if (now_t >= fdl_ff) begin
                  state_in = S_FAIL;
                  pend_in  = 1'b0;
                  act0     = sskf_pkg::ACT_FAILED;
                  ok       = 1'b0;
               end
            end else if (state_ff == S_ESTB) begin
               if (send) begin
                  esd_in = esd_new;
                  rdl_in = rdl_eff;
                  act0   = sskf_pkg::ACT_ECHO_REQ;
               end
               pend_in = pend_eff;
               if (echo_fail) begin
                  state_in = S_FAIL;
                  pend_in  = 1'b0;
                  ok       = 1'b0;
                  if (send) begin
                     two  = 1'b1;
                     act1 = sskf_pkg::ACT_FAILED;
                  end else begin
                     act0 = sskf_pkg::ACT_FAILED;
                  end
               end
            end else begin
               ok = 1'b0;
            end
         end
         sskf_pkg::CMD_MSG: begin
            if (state_ff == S_WAIT) begin
               if (cls_ff == sskf_pkg::CLS_FEAT_REQ) begin
                  state_in = S_ESTB;
                  esd_in   = esd_new;
                  act0     = sskf_pkg::ACT_FEAT_REPLY;
               end else begin
                  state_in = S_FAIL;
                  pend_in  = 1'b0;
                  act0     = sskf_pkg::ACT_FAILED;
                  ok       = 1'b0;
               end
            end else if (state_ff == S_ESTB) begin
               unique case (cls_ff)
                  sskf_pkg::CLS_ECHO_REQ: act0 = sskf_pkg::ACT_ECHO_REPLY;
                  sskf_pkg::CLS_ECHO_RES: pend_in = 1'b0;
                  sskf_pkg::CLS_PKT_OUT, sskf_pkg::CLS_FLOW_MOD,
                  sskf_pkg::CLS_GROUP_MOD, sskf_pkg::CLS_PORT_MOD,
                  sskf_pkg::CLS_TABLE_MOD: begin
                     if (role_ff == sskf_pkg::ROLE_SLAVE) begin
                        act0 = sskf_pkg::ACT_SLAVE_ERR;
                     end else begin
                        act0 = sskf_pkg::ACT_TO_AGENT;
                        msg0 = cls_ff;
                     end
                  end
                  sskf_pkg::CLS_ROLE_REQ: begin
                     role_in = role_in_ff;
                     act0    = sskf_pkg::ACT_TO_AGENT;
                     msg0    = cls_ff;
                  end
                  sskf_pkg::CLS_OTHER: ;
                  default: begin
                     act0 = sskf_pkg::ACT_TO_AGENT;
                     msg0 = cls_ff;
                  end
               endcase
            end else begin
               state_in = S_FAIL;
               pend_in  = 1'b0;
               act0     = sskf_pkg::ACT_FAILED;
               ok       = 1'b0;
            end
         end
         sskf_pkg::CMD_ROLE: role_in = role_in_ff;
         default: ok = 1'b0;
      endcase
   end

   // results towards the output queue
   always_comb begin
      push.push0           = fire;
      push.push1           = fire && two;
      push.res0.action     = act0;
      push.res0.agent_msg  = msg0;
      push.res0.ok         = ok;
      push.res0.conn_state = 2'(state_in);
      push.res0.last       = !two;
      push.res1.action     = act1;
      push.res1.agent_msg  = 4'd0;
      push.res1.ok         = ok;
      push.res1.conn_state = 2'(state_in);
      push.res1.last       = 1'b1;
   end

   // input register and session registers
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         cmd_ff     <= in_cmd;
         now_ff     <= in_now;
         cls_ff     <= in_msg_class;
         role_in_ff <= in_new_role;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= S_IDLE;
         role_ff  <= 2'd0;
         fdl_ff   <= '0;
         esd_ff   <= '0;
         pend_ff  <= 1'b0;
         rdl_ff   <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (fire) begin
            state_ff <= state_in;
            role_ff  <= role_in;
            fdl_ff   <= fdl_in;
            esd_ff   <= esd_in;
            pend_ff  <= pend_in;
            rdl_ff   <= rdl_in;
         end
      end
   end

endmodule

// ----- rtl/core/sskf_rsp_queue.sv -----
`timescale 1ns / 1ps

module sskf_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  sskf_pkg::rsp_push_type push,
   output logic                   room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output sskf_pkg::rsp_entry_type out_entry
);

   sskf_pkg::rsp_entry_type mem_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   // space for the two results of one item
   assign room      = count_ff <= 3'd2;
   assign out_valid = count_ff != 3'd0;
   assign out_entry = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   assign wr_in    = wr_ff + 2'(push.push0) + 2'(push.push1);
   assign rd_in    = rd_ff + 2'(pop);
   assign count_in = count_ff + 3'(push.push0) + 3'(push.push1) - 3'(pop);

   // entry storage
   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ff] <= push.res0;
      end
      if (push.push1) begin
         mem_ff[wr_ff + 2'd1] <= push.res1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/core/switch_session_keepalive_fsm.sv -----
`timescale 1ns / 1ps
// result path: an accepted item passes the input register and then the result queue
// throughput: one item per cycle while the result queue has room; an item with two results
// pushes both at once, and the four-entry result queue then back-pressures req_tready
// reset (synchronous, active high): session idle, role and deadlines zero, no echo pending,
// result queue empty, timing registers back to their default tick counts

module switch_session_keepalive_fsm #(
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd[2:0], now[34:3], msg_class[38:35], new_role[40:39]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // action[3:0], agent_msg[7:4], ok[8], conn_state[10:9]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   sskf_pkg::cfg_type       cfg_ff;
   sskf_pkg::rsp_push_type  push;
   sskf_pkg::rsp_entry_type head;
   logic                    room;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feature_wait_ticks  <= sskf_pkg::FEATURE_WAIT_RESET;
         cfg_ff.echo_interval_ticks <= sskf_pkg::ECHO_INTERVAL_RESET;
         cfg_ff.echo_wait_ticks     <= sskf_pkg::ECHO_WAIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            sskf_pkg::CSR_FEATURE_WAIT:  cfg_ff.feature_wait_ticks  <= csr_wdata;
            sskf_pkg::CSR_ECHO_INTERVAL: cfg_ff.echo_interval_ticks <= csr_wdata;
            sskf_pkg::CSR_ECHO_WAIT:     cfg_ff.echo_wait_ticks     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // session core
   sskf_session #(
      .TIME_BITS (TIME_BITS)
   ) u_session (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_cmd       (req_tdata[2:0]),
      .in_now       (req_tdata[34:3]),
      .in_msg_class (req_tdata[38:35]),
      .in_new_role  (req_tdata[40:39]),
      .cfg          (cfg_ff),
      .out_room     (room),
      .push         (push)
   );

   // result queue
   sskf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (head)
   );

   // result transfer packing
   assign rsp_tdata = {5'd0, head.conn_state, head.ok, head.agent_msg, 4'(head.action)};
   assign rsp_tlast = head.last;

endmodule

// ----- tb/sv/session_checker.sv -----
`timescale 1ns / 1ps

module session_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // cmd[2:0], now[34:3], msg_class[38:35], new_role[40:39]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // action[3:0], agent_msg[7:4], ok[8], conn_state[10:9]
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          results_due
);

   localparam int REPORT_MAX = 10;

   typedef enum logic [1:0] {
      SESS_IDLE   = 2'd0,
      SESS_WAIT   = 2'd1,
      SESS_UP     = 2'd2,
      SESS_FAILED = 2'd3
   } session_type;

   // timing registers as the block should hold them
   logic [31:0] feat_wait;
   logic [31:0] echo_every;
   logic [31:0] echo_wait;

   // session state as the block should hold it
   session_type sess;
   logic [1:0]  role_now;
   logic [31:0] feat_due;
   logic [31:0] echo_send_due;
   logic        echo_out;
   logic [31:0] echo_reply_due;

   sskf_pkg::rsp_entry_type due_results[$];
   int                      results_seen;

   // deadline sum, clamped at the largest timestamp
   function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic void drop_session();
      sess     = SESS_FAILED;
      echo_out = 1'b0;
   endfunction

   // advance the session by one event and queue the results it gives
   task automatic step_session(input logic [2:0] cmd, input logic [31:0] stamp,
                               input logic [3:0] cls, input logic [1:0] role);
      sskf_pkg::action_type    acts [2];
      logic [3:0]              msgs [2];
      int                      n;
      logic                    ok;
      sskf_pkg::rsp_entry_type e;
      n       = 1;
      ok      = 1'b1;
      acts[0] = sskf_pkg::ACT_NONE;
      acts[1] = sskf_pkg::ACT_NONE;
      msgs[0] = '0;
      msgs[1] = '0;
      case (cmd)
         sskf_pkg::CMD_INIT: begin
            if (sess == SESS_IDLE) begin
               sess     = SESS_WAIT;
               feat_due = sat_sum(stamp, feat_wait);
               acts[0]  = sskf_pkg::ACT_AGENT_INIT;
            end else begin
               drop_session();
               acts[0] = sskf_pkg::ACT_FAILED;
               ok      = 1'b0;
            end
         end
         sskf_pkg::CMD_FINI: begin
            sess     = SESS_IDLE;
            echo_out = 1'b0;
            acts[0]  = sskf_pkg::ACT_AGENT_FINI;
            ok       = 1'b0;
         end
         sskf_pkg::CMD_TICK: begin
            if (sess == SESS_WAIT) begin
               if (stamp >= feat_due) begin
                  drop_session();
                  acts[0] = sskf_pkg::ACT_FAILED;
                  ok      = 1'b0;
               end
            end else if (sess == SESS_UP) begin
               n = 0;
               // periodic echo; a pending echo keeps its older deadline
               if (stamp >= echo_send_due) begin
                  acts[n] = sskf_pkg::ACT_ECHO_REQ;
                  n++;
                  if (!echo_out) begin
                     echo_out       = 1'b1;
                     echo_reply_due = sat_sum(stamp, echo_wait);
                  end
                  echo_send_due = sat_sum(stamp, echo_every);
               end
               if (echo_out && stamp >= echo_reply_due) begin
                  drop_session();
                  acts[n] = sskf_pkg::ACT_FAILED;
                  n++;
                  ok = 1'b0;
               end
               if (n == 0) n = 1;
            end else begin
               ok = 1'b0;
            end
         end
         sskf_pkg::CMD_MSG: begin
            if (sess == SESS_WAIT) begin
               if (cls == sskf_pkg::CLS_FEAT_REQ) begin
                  sess          = SESS_UP;
                  echo_send_due = sat_sum(stamp, echo_every);
                  acts[0]       = sskf_pkg::ACT_FEAT_REPLY;
               end else begin
                  drop_session();
                  acts[0] = sskf_pkg::ACT_FAILED;
                  ok      = 1'b0;
               end
            end else if (sess == SESS_UP) begin
               case (cls)
                  sskf_pkg::CLS_ECHO_REQ: acts[0] = sskf_pkg::ACT_ECHO_REPLY;
                  sskf_pkg::CLS_ECHO_RES: echo_out = 1'b0;
                  sskf_pkg::CLS_PKT_OUT, sskf_pkg::CLS_FLOW_MOD,
                  sskf_pkg::CLS_GROUP_MOD, sskf_pkg::CLS_PORT_MOD,
                  sskf_pkg::CLS_TABLE_MOD: begin
                     if (role_now == sskf_pkg::ROLE_SLAVE) begin
                        acts[0] = sskf_pkg::ACT_SLAVE_ERR;
                     end else begin
                        acts[0] = sskf_pkg::ACT_TO_AGENT;
                        msgs[0] = cls;
                     end
                  end
                  sskf_pkg::CLS_ROLE_REQ: begin
                     role_now = role;
                     acts[0]  = sskf_pkg::ACT_TO_AGENT;
                     msgs[0]  = cls;
                  end
                  sskf_pkg::CLS_OTHER: ;
                  default: begin
                     acts[0] = sskf_pkg::ACT_TO_AGENT;
                     msgs[0] = cls;
                  end
               endcase
            end else begin
               drop_session();
               acts[0] = sskf_pkg::ACT_FAILED;
               ok      = 1'b0;
            end
         end
         sskf_pkg::CMD_ROLE: role_now = role;
         default: ok = 1'b0;
      endcase
      for (int k = 0; k < n; k++) begin
         e.action     = acts[k];
         e.agent_msg  = msgs[k];
         e.ok         = ok;
         e.conn_state = sess;
         e.last       = (k == n - 1);
         due_results  = {due_results, e};
      end
   endtask

   // compare one result transfer with the oldest expectation
   task automatic check_result();
      sskf_pkg::rsp_entry_type want;
      logic [3:0]              got_act;
      logic [3:0]              got_msg;
      logic                    got_ok;
      logic [1:0]              got_state;
      logic                    got_last;
      got_act   = rsp_tdata[3:0];
      got_msg   = rsp_tdata[7:4];
      got_ok    = rsp_tdata[8];
      got_state = rsp_tdata[10:9];
      got_last  = rsp_tlast;
      results_seen++;
      if (due_results.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("result %0d: none expected, ", results_seen,
                     "got action %0d agent_msg %0d ok %0b state %0d last %0b",
                     got_act, got_msg, got_ok, got_state, got_last);
      end else begin
         want = due_results.pop_front();
         if (got_act != want.action || got_msg != want.agent_msg || got_ok != want.ok ||
             got_state != want.conn_state || got_last != want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("result %0d: expected action %0d agent_msg %0d ok %0b state %0d last %0b",
                        results_seen, want.action, want.agent_msg, want.ok, want.conn_state,
                        want.last);
            if (fail_count <= REPORT_MAX)
               $display("result %0d:      got action %0d agent_msg %0d ok %0b state %0d last %0b",
                        results_seen, got_act, got_msg, got_ok, got_state, got_last);
         end
      end
   endtask

   // results are checked before the new event is predicted, so a stray
   // result never pairs with an event accepted on the same edge
   always @(posedge clock) begin
      if (reset) begin
         feat_wait      = sskf_pkg::FEATURE_WAIT_RESET;
         echo_every     = sskf_pkg::ECHO_INTERVAL_RESET;
         echo_wait      = sskf_pkg::ECHO_WAIT_RESET;
         sess           = SESS_IDLE;
         role_now       = '0;
         feat_due       = '0;
         echo_send_due  = '0;
         echo_out       = 1'b0;
         echo_reply_due = '0;
         results_seen   = 0;
         due_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_we) begin
            case (csr_addr)
               sskf_pkg::CSR_FEATURE_WAIT:  feat_wait  = csr_wdata;
               sskf_pkg::CSR_ECHO_INTERVAL: echo_every = csr_wdata;
               sskf_pkg::CSR_ECHO_WAIT:     echo_wait  = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            step_session(req_tdata[2:0], req_tdata[34:3], req_tdata[38:35], req_tdata[40:39]);
      end
      results_due = due_results.size();
   end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT   = 4000;
   localparam int PHASE_ITEMS  = 365;
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 6;

   // codes with no name in the package
   localparam logic [2:0] CMD_SPARE_LO   = 3'd5;
   localparam logic [3:0] CLS_GET_CONFIG = 4'd4;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // cmd[2:0], now[34:3], msg_class[38:35], new_role[40:39]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // action[3:0], agent_msg[7:4], ok[8], conn_state[10:9]
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [31:0] csr_wdata;

   int fail_count;
   int results_due;
   int items_sent = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;

   switch_session_keepalive_fsm uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   session_checker session_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timestamp step, clamped at the largest value
   function automatic logic [31:0] later(input logic [31:0] a, input logic [31:0] d);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, d};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // offer one event and hold it until the transfer happens
   task automatic push_item(input logic [2:0] c, input logic [31:0] stamp,
                            input logic [3:0] cls, input logic [1:0] role);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tdata  <= {7'd0, role, cls, stamp, c};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (c <= sskf_pkg::CMD_ROLE) items_sent++;
   endtask

   // wait until every expected result has arrived and the block has settled
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_timers(input logic [31:0] fw, input logic [31:0] ei,
                             input logic [31:0] ew);
      drain_results();
      csr_we    <= 1'b1;
      csr_addr  <= sskf_pkg::CSR_FEATURE_WAIT;
      csr_wdata <= fw;
      @(posedge clock);
      csr_addr  <= sskf_pkg::CSR_ECHO_INTERVAL;
      csr_wdata <= ei;
      @(posedge clock);
      csr_addr  <= sskf_pkg::CSR_ECHO_WAIT;
      csr_wdata <= ew;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // one session: init, feature wait, established traffic, then usually fini
   task automatic run_session(input logic [31:0] span);
      logic [31:0] t;
      logic [3:0]  cls;
      int          pick;
      int          body;
      case ($urandom_range(0, 7))
         0: t = '0;
         1: t = 32'hFFFF_FFFF - $urandom_range(0, span);
         default: t = $urandom;
      endcase
      push_item(sskf_pkg::CMD_INIT, t, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      repeat ($urandom_range(0, 2)) begin
         t = later(t, $urandom_range(0, span));
         push_item(sskf_pkg::CMD_TICK, t, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      end
      cls = ($urandom_range(0, 9) != 0) ? sskf_pkg::CLS_FEAT_REQ : 4'($urandom_range(0, 15));
      push_item(sskf_pkg::CMD_MSG, t, cls, 2'($urandom_range(0, 3)));
      body = $urandom_range(5, 25);
      repeat (body) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            t = later(t, $urandom_range(0, span));
            push_item(sskf_pkg::CMD_TICK, t, 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
         end else if (pick < 52) begin
            push_item(sskf_pkg::CMD_MSG, t, sskf_pkg::CLS_ECHO_RES, 2'($urandom_range(0, 3)));
         end else if (pick < 77) begin
            cls = $urandom_range(0, 1)
                  ? 4'($urandom_range(sskf_pkg::CLS_PKT_OUT, sskf_pkg::CLS_TABLE_MOD))
                  : 4'($urandom_range(0, 15));
            push_item(sskf_pkg::CMD_MSG, t, cls, 2'($urandom_range(0, 3)));
         end else if (pick < 88) begin
            push_item(sskf_pkg::CMD_ROLE, t, 4'($urandom_range(0, 15)),
                      $urandom_range(0, 1) ? sskf_pkg::ROLE_SLAVE : 2'($urandom_range(0, 3)));
         end else begin
            push_item(sskf_pkg::CMD_MSG, t, sskf_pkg::CLS_ROLE_REQ,
                      $urandom_range(0, 1) ? sskf_pkg::ROLE_SLAVE : 2'($urandom_range(0, 3)));
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
         push_item(sskf_pkg::CMD_FINI, t, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      else if (pick < 85)
         push_item(sskf_pkg::CMD_INIT, t, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
   endtask

   // mostly whole sessions, with raw noise events in between
   task automatic run_phase(input int goal, input logic [31:0] span);
      while (items_sent < goal) begin
         if ($urandom_range(0, 6) == 0)
            push_item(3'($urandom_range(0, 7)), $urandom, 4'($urandom_range(0, 15)),
                      2'($urandom_range(0, 3)));
         else
            run_session(span);
      end
   endtask

   // result side: random stalls, one long hold-off, none at the end
   initial begin : result_sink
      bit held;
      held = 1'b0;
      forever begin
         if (!held && items_sent >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clock);
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: idle and failed handling, spare codes, role changes
      push_item(sskf_pkg::CMD_TICK, 32'd0, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd0, sskf_pkg::CLS_FLOW_MOD, 2'd0);
      push_item(sskf_pkg::CMD_FINI, 32'd0, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(CMD_SPARE_LO, 32'hFFFF_FFFF, sskf_pkg::CLS_OTHER, sskf_pkg::ROLE_SLAVE);
      push_item(sskf_pkg::CMD_ROLE, 32'd0, sskf_pkg::CLS_OTHER, sskf_pkg::ROLE_SLAVE);
      push_item(sskf_pkg::CMD_INIT, 32'd100, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_INIT, 32'd200, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_FINI, 32'd200, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      // feature deadline clamped at the top of the time range
      push_item(sskf_pkg::CMD_INIT, 32'hFFFF_F000, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_TICK, 32'hFFFF_FFFE, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_TICK, 32'hFFFF_FFFF, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      // wrong message during feature wait
      push_item(sskf_pkg::CMD_FINI, 32'd0, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_INIT, 32'd10, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd20, sskf_pkg::CLS_ECHO_REQ, 2'd0);
      push_item(sskf_pkg::CMD_FINI, 32'd20, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_INIT, 32'd10, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd20, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      // modify messages as slave and as master, role request, plain messages
      push_item(sskf_pkg::CMD_MSG, 32'd30, sskf_pkg::CLS_PKT_OUT, 2'd0);
      push_item(sskf_pkg::CMD_ROLE, 32'd30, sskf_pkg::CLS_OTHER, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd30, sskf_pkg::CLS_FLOW_MOD, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd40, sskf_pkg::CLS_ROLE_REQ, sskf_pkg::ROLE_SLAVE);
      push_item(sskf_pkg::CMD_MSG, 32'd40, sskf_pkg::CLS_TABLE_MOD, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd40, sskf_pkg::CLS_ECHO_REQ, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd40, sskf_pkg::CLS_OTHER, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd40, CLS_GET_CONFIG, 2'd0);
      // echo cycle: cleared reply, then a stale pending echo fails the session
      push_item(sskf_pkg::CMD_TICK, 32'd5020, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_MSG, 32'd5030, sskf_pkg::CLS_ECHO_RES, 2'd0);
      push_item(sskf_pkg::CMD_TICK, 32'd10020, sskf_pkg::CLS_FEAT_REQ, 2'd0);
      push_item(sskf_pkg::CMD_TICK, 32'd15020, sskf_pkg::CLS_FEAT_REQ, 2'd0);

      // random sessions under several timer settings
      set_timers(32'd20, 32'd30, 32'd50);
      run_phase(items_sent + PHASE_ITEMS, 32'd60);
      set_timers(32'd0, 32'd0, 32'd0);
      run_phase(items_sent + PHASE_ITEMS, 32'd3);
      set_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(items_sent + PHASE_ITEMS, 32'hFFFF_FFFF);
      set_timers(32'd100, 32'd10, 32'd25);
      run_phase(items_sent + PHASE_ITEMS, 32'd40);
      set_timers($urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 200));
      quiet = 1'b1;
      run_phase(items_sent + PHASE_ITEMS, 32'd250);

      drain_results();
      if (fail_count == 0 && results_due == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
